### src/apie_pkg.sv
// Shared types, character constants and pattern tables for the +IPD payload extractor.
package apie_pkg;

   localparam int LEN_W = 14;   // frame length accumulator and remaining count
   localparam int CNT_W = 16;   // delivered payload count, saturating
   localparam int POS_W = 3;    // pattern matcher position

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   typedef enum logic [1:0] {
      PAT_IPD,
      PAT_ERR,
      PAT_OK
   } pat_id_type;

   // matcher control from the top level
   typedef struct packed {
      logic step;    // advance on this kept byte
      logic clear;   // back to the start, wins over step
   } mt_ctl_type;

   function automatic logic [POS_W-1:0] pat_len(input pat_id_type id);
      logic [POS_W-1:0] len;
      case (id)
         PAT_IPD: len = 3'd5;
         PAT_ERR: len = 3'd7;
         PAT_OK:  len = 3'd6;
         default: len = 3'd5;
      endcase
      return len;
   endfunction

   // "+IPD,", "ERROR\r\n", "OK\r\n\r\n"
   function automatic logic [7:0] pat_char(input pat_id_type id, input logic [POS_W-1:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (id)
         PAT_IPD: begin
            case (pos)
               3'd0:    ch = 8'h2B;
               3'd1:    ch = 8'h49;
               3'd2:    ch = 8'h50;
               3'd3:    ch = 8'h44;
               3'd4:    ch = 8'h2C;
               default: ch = 8'h00;
            endcase
         end
         PAT_ERR: begin
            case (pos)
               3'd0:    ch = 8'h45;
               3'd1:    ch = 8'h52;
               3'd2:    ch = 8'h52;
               3'd3:    ch = 8'h4F;
               3'd4:    ch = 8'h52;
               3'd5:    ch = 8'h0D;
               3'd6:    ch = 8'h0A;
               default: ch = 8'h00;
            endcase
         end
         PAT_OK: begin
            case (pos)
               3'd0:    ch = 8'h4F;
               3'd1:    ch = 8'h4B;
               3'd2:    ch = 8'h0D;
               3'd3:    ch = 8'h0A;
               3'd4:    ch = 8'h0D;
               3'd5:    ch = 8'h0A;
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### src/apie_matcher.sv
// Fixed-pattern string matcher: one position register, restart on mismatch.
module apie_matcher #(
   parameter apie_pkg::pat_id_type PAT_ID = apie_pkg::PAT_IPD
) (
   input  logic                   clock,
   input  logic                   reset,
   input  apie_pkg::mt_ctl_type   ctl,
   input  logic [7:0]             rx_byte,
   output logic                   hit
);
   import apie_pkg::*;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] pos_eff;
   logic [POS_W-1:0] pos_inc;
   logic [POS_W-1:0] pos_nxt;
   logic [POS_W-1:0] len;

   always_comb begin
      len     = pat_len(PAT_ID);
      pos_eff = (pos_ff >= len) ? '0 : pos_ff;
      pos_inc = pos_eff + 1'b1;
      hit     = 1'b0;
      if (rx_byte == pat_char(PAT_ID, pos_eff)) begin
         if (pos_inc == len) begin
            hit     = 1'b1;
            pos_nxt = '0;
         end else begin
            pos_nxt = pos_inc;
         end
      end else if (rx_byte == pat_char(PAT_ID, '0)) begin
         pos_nxt = POS_W'(1);
      end else begin
         pos_nxt = '0;
      end
   end

   always_comb begin
      if (ctl.clear) begin
         pos_in = '0;
      end else if (ctl.step) begin
         pos_in = pos_nxt;
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### src/at_ipd_payload_extractor_core.sv
// Top level: +IPD frame parser that turns a modem byte stream into payload items.
// An accepted input item's result item is in the output register in the next cycle.
// Throughput: one item per cycle; the next item is taken while a result waits, as long as
//   rsp_tready rises in that cycle (single output register, parser state updated on accept).
// Reset: synchronous, active high; clears parser state, matchers and the output valid flag.
// Every input item gives exactly one result item.
module at_ipd_payload_extractor_core #(
   parameter int BYTE_LIMIT     = 1500,  // kept bytes since the last clear that end the run
   parameter int MAX_LEN_DIGITS = 4      // length digits taken from the header
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   input  logic [0:0]  req_tuser,    // [0] action (1 = receive ended)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] payload_byte, [23:8] payload_count
   output logic [1:0]  rsp_tuser,    // [0] payload_valid, [1] status
   output logic        rsp_tlast     // done_res: run finished on this item
);
   import apie_pkg::*;

   localparam int BSC_W = $clog2(BYTE_LIMIT + 1);
   localparam int DIG_W = $clog2(MAX_LEN_DIGITS + 1);

   // ---------------------------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------------------------
   logic             in_frame_ff,  in_frame_in;
   logic             in_header_ff, in_header_in;
   logic [DIG_W-1:0] digits_ff,    digits_in;
   logic [LEN_W-1:0] accum_ff,     accum_in;
   logic [LEN_W-1:0] remain_ff,    remain_in;
   logic [BSC_W-1:0] bsc_ff,       bsc_in;
   logic [CNT_W-1:0] count_ff,     count_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      rsp_data_ff;
   logic [1:0]       rsp_user_ff;
   logic             rsp_last_ff;

   logic             accept;
   logic             action;
   logic [7:0]       rx_byte;
   logic             kept;
   logic             last_pay;
   logic             done_c;
   logic             status_c;
   logic             valid_c;
   logic [7:0]       pbyte_c;
   logic [LEN_W-1:0] remain_dec;
   logic [BSC_W-1:0] bsc_inc;
   logic             hit_ipd, hit_err, hit_ok;
   mt_ctl_type       mt_ctl;

   // output register frees up when empty or being taken this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign action     = req_tuser[0];
   assign rx_byte    = req_tdata;

   assign remain_dec = (remain_ff != '0) ? remain_ff - 1'b1 : '0;
   // bsc_ff stays below BYTE_LIMIT, so the increment always fits
   assign bsc_inc    = bsc_ff + 1'b1;

   // ---------------------------------------------------------------------------------------
   // Pattern matchers, advanced only on kept bytes
   // ---------------------------------------------------------------------------------------
   assign mt_ctl.step  = accept && kept;
   assign mt_ctl.clear = accept && (done_c || last_pay);

   apie_matcher #(.PAT_ID(PAT_IPD)) u_match_ipd (
      .clock(clock), .reset(reset), .ctl(mt_ctl), .rx_byte(rx_byte), .hit(hit_ipd)
   );
   apie_matcher #(.PAT_ID(PAT_ERR)) u_match_err (
      .clock(clock), .reset(reset), .ctl(mt_ctl), .rx_byte(rx_byte), .hit(hit_err)
   );
   apie_matcher #(.PAT_ID(PAT_OK)) u_match_ok (
      .clock(clock), .reset(reset), .ctl(mt_ctl), .rx_byte(rx_byte), .hit(hit_ok)
   );

   // ---------------------------------------------------------------------------------------
   // Per-item parser step
   // ---------------------------------------------------------------------------------------
   always_comb begin
      in_frame_in  = in_frame_ff;
      in_header_in = in_header_ff;
      digits_in    = digits_ff;
      accum_in     = accum_ff;
      remain_in    = remain_ff;
      bsc_in       = bsc_ff;
      count_in     = count_ff;
      kept         = 1'b0;
      last_pay     = 1'b0;
      done_c       = 1'b0;
      status_c     = 1'b0;
      valid_c      = 1'b0;
      pbyte_c      = 8'h00;

      if (action) begin
         // end of stream: error if payload still owed or header half read
         done_c   = 1'b1;
         status_c = (in_frame_ff && remain_ff != '0) || in_header_ff;
      end else if (in_header_ff) begin
         if (rx_byte == CH_COLON) begin
            in_header_in = 1'b0;
            if (accum_ff != '0) begin
               in_frame_in = 1'b1;
               remain_in   = accum_ff;
            end
         end else if (rx_byte inside {[CH_0:CH_9]}) begin
            if (digits_ff < DIG_W'(MAX_LEN_DIGITS)) begin
               // accum * 10 + digit, wrapping at the accumulator width
               accum_in  = {accum_ff[LEN_W-4:0], 3'b000} + {accum_ff[LEN_W-2:0], 1'b0}
                         + {{(LEN_W-4){1'b0}}, rx_byte[3:0]};
               digits_in = digits_ff + 1'b1;
            end
         end else begin
            // any other byte stops digit taking
            digits_in = DIG_W'(MAX_LEN_DIGITS);
         end
      end else begin
         kept = 1'b1;
         if (in_frame_ff) begin
            valid_c   = 1'b1;
            pbyte_c   = rx_byte;
            count_in  = (count_ff != '1) ? count_ff + 1'b1 : count_ff;
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               // last payload byte closes the frame and clears the kept-byte history
               in_frame_in = 1'b0;
               bsc_in      = '0;
               kept        = 1'b0;
               last_pay    = 1'b1;
            end
         end
         if (kept) begin
            bsc_in = bsc_inc;
            if (bsc_inc >= BSC_W'(BYTE_LIMIT)) begin
               // byte limit wins over pattern hits on the same byte
               done_c   = 1'b1;
               status_c = in_frame_in && (remain_in != '0);
            end else begin
               if (hit_ipd && !in_frame_in) begin
                  in_header_in = 1'b1;
                  digits_in    = '0;
                  accum_in     = '0;
               end
               if (hit_err) begin
                  done_c   = 1'b1;
                  status_c = 1'b1;
               end else if (hit_ok) begin
                  in_frame_in = 1'b0;
                  remain_in   = '0;
               end
            end
         end
      end
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         in_header_ff <= 1'b0;
         digits_ff    <= '0;
         accum_ff     <= '0;
         remain_ff    <= '0;
         bsc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (done_c) begin
               // run over: back to the reset picture for the next item
               in_frame_ff  <= 1'b0;
               in_header_ff <= 1'b0;
               digits_ff    <= '0;
               accum_ff     <= '0;
               remain_ff    <= '0;
               bsc_ff       <= '0;
               count_ff     <= '0;
            end else begin
               in_frame_ff  <= in_frame_in;
               in_header_ff <= in_header_in;
               digits_ff    <= digits_in;
               accum_ff     <= accum_in;
               remain_ff    <= remain_in;
               bsc_ff       <= bsc_in;
               count_ff     <= count_in;
            end
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {count_in, pbyte_c};
         rsp_user_ff <= {status_c, valid_c};
         rsp_last_ff <= done_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------------
`ifndef SYNTHESIS
   a_frame_owes_bytes : assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> remain_ff != '0)
      else $error("open frame with nothing remaining");

   a_header_not_frame : assert property (@(posedge clock) disable iff (reset)
      !(in_frame_ff && in_header_ff))
      else $error("header and frame open together");

   a_limit_bound : assert property (@(posedge clock) disable iff (reset)
      bsc_ff < BSC_W'(BYTE_LIMIT))
      else $error("kept byte count reached the limit without ending the run");

   a_done_resets : assert property (@(posedge clock) disable iff (reset)
      accept && done_c |=> !in_frame_ff && !in_header_ff && count_ff == '0 && bsc_ff == '0)
      else $error("state not cleared after end of run");
`endif

endmodule

### tb/at_ipd_payload_extractor_core_tb.sv
// Self-checking testbench for the +IPD payload extractor: directed table, random frames, checker.
`timescale 1ns / 1ps

module at_ipd_payload_extractor_core_tb;
   import apie_pkg::*;

   localparam int BYTE_LIMIT  = 1500;
   localparam int MAX_DIGITS  = 4;
   localparam int HOLD_CYCLES = 64;    // long receiver hold-off
   localparam int RAND_ITEMS  = 300;

   localparam logic ACT_BYTE  = 1'b0;  // rx_byte carries a received character
   localparam logic ACT_END   = 1'b1;  // receive ended or timed out
   localparam logic ST_OK     = 1'b0;
   localparam logic ST_ERR    = 1'b1;
   localparam logic CHK_NONE  = 1'b0;  // row checked against the predictor
   localparam logic CHK_FIXED = 1'b1;  // row carries its own expected result

   // one result item, fields in the order they are reported
   typedef struct packed {
      logic             pv;       // payload_valid
      logic [7:0]       pbyte;    // payload_byte
      logic [CNT_W-1:0] count;    // payload_count
      logic             done;     // done_res
      logic             status;
   } ext_result_type;

   typedef struct packed {
      logic           act;
      logic [7:0]     rx;
      logic           chk;
      ext_result_type want;
   } dir_row_type;

   localparam ext_result_type NO_RES        = '0;
   localparam ext_result_type DONE_OK_ZERO  = {1'b0, 8'h00, 16'd0, 1'b1, ST_OK};
   localparam ext_result_type DONE_OK_ONE   = {1'b0, 8'h00, 16'd1, 1'b1, ST_OK};
   localparam ext_result_type DONE_ERR_ZERO = {1'b0, 8'h00, 16'd0, 1'b1, ST_ERR};
   localparam ext_result_type PAYLOAD_FF    = {1'b1, 8'hFF, 16'd1, 1'b0, ST_OK};

   localparam logic [55:0] IPD_STR = "+IPD,";
   localparam logic [55:0] ERR_STR = "ERROR\r\n";
   localparam logic [55:0] OK_STR  = "OK\r\n\r\n";

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] rx_byte
   logic [0:0]  req_tuser;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;    // [7:0] payload_byte, [23:8] payload_count
   logic [1:0]  rsp_tuser;    // [0] payload_valid, [1] status
   logic        rsp_tlast;    // done_res

   at_ipd_payload_extractor_core #(
      .BYTE_LIMIT     (BYTE_LIMIT),
      .MAX_LEN_DIGITS (MAX_DIGITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the parser
   // ---------------------------------------------------------------
   logic             fr_open;
   logic             hdr_open;
   logic [2:0]       hdr_digits;
   logic [LEN_W-1:0] len_acc;
   logic [LEN_W-1:0] owed;
   logic [POS_W-1:0] ipd_pos, err_pos, ok_pos;
   logic [10:0]      kept_cnt;
   logic [CNT_W-1:0] deliv_cnt;

   ext_result_type res_due[$];   // results still owed by the block, oldest first

   int errors        = 0;
   int sent_items    = 0;
   int n_results     = 0;
   int n_payload     = 0;
   int n_runs        = 0;
   int n_runs_err    = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;   // bumped by the stimulus to ask for a long hold-off

   function automatic void parser_clear();
      fr_open    = 1'b0;
      hdr_open   = 1'b0;
      hdr_digits = '0;
      len_acc    = '0;
      owed       = '0;
      ipd_pos    = '0;
      err_pos    = '0;
      ok_pos     = '0;
      kept_cnt   = '0;
      deliv_cnt  = '0;
   endfunction

   // Advance one pattern matcher; none of the patterns overlaps itself, so a
   // mismatch only needs a look at the first character.
   function automatic logic [POS_W-1:0] match_advance(input logic [POS_W-1:0] pos,
         input logic [7:0] c, input logic [55:0] pat, input int len, output bit hit);
      int p;
      logic [7:0] want_ch, first_ch;
      hit      = 1'b0;
      p        = (pos >= len) ? 0 : int'(pos);
      want_ch  = pat[8*(len-1-p) +: 8];
      first_ch = pat[8*(len-1) +: 8];
      if (c == want_ch) begin
         p++;
         if (p == len) begin
            hit = 1'b1;
            return '0;
         end
         return POS_W'(p);
      end
      return (c == first_ch) ? POS_W'(1) : POS_W'(0);
   endfunction

   function automatic ext_result_type ipd_predict(input logic act, input logic [7:0] c);
      ext_result_type r;
      bit kept, hit_ipd, hit_err, hit_ok;
      r    = '0;
      kept = 1'b1;
      if (act == ACT_END) begin
         r.done   = 1'b1;
         r.status = ((fr_open && owed != 0) || hdr_open) ? ST_ERR : ST_OK;
      end else if (hdr_open) begin
         if (c == CH_COLON) begin
            hdr_open = 1'b0;
            // zero length: no frame, nothing cleared
            if (len_acc != 0) begin
               fr_open = 1'b1;
               owed    = len_acc;
            end
         end else if (c >= CH_0 && c <= CH_9) begin
            if (hdr_digits < MAX_DIGITS) begin
               len_acc    = LEN_W'(len_acc * 10 + (c - CH_0));
               hdr_digits = hdr_digits + 3'd1;
            end
         end else begin
            hdr_digits = 3'(MAX_DIGITS);
         end
      end else begin
         if (fr_open) begin
            r.pv    = 1'b1;
            r.pbyte = c;
            if (deliv_cnt != '1) deliv_cnt = deliv_cnt + 1'b1;
            if (owed != 0) owed = owed - 1'b1;
            // last payload byte closes the frame and clears the kept bytes
            if (owed == 0) begin
               fr_open  = 1'b0;
               ipd_pos  = '0;
               err_pos  = '0;
               ok_pos   = '0;
               kept_cnt = '0;
               kept     = 1'b0;
            end
         end
         if (kept) begin
            if (kept_cnt < 11'd2047) kept_cnt = kept_cnt + 1'b1;
            ipd_pos = match_advance(ipd_pos, c, IPD_STR, 5, hit_ipd);
            err_pos = match_advance(err_pos, c, ERR_STR, 7, hit_err);
            ok_pos  = match_advance(ok_pos,  c, OK_STR,  6, hit_ok);
            if (kept_cnt >= BYTE_LIMIT) begin
               // byte limit wins over the patterns of the same byte
               r.done   = 1'b1;
               r.status = (fr_open && owed != 0) ? ST_ERR : ST_OK;
            end else begin
               if (hit_ipd && !fr_open) begin
                  hdr_open   = 1'b1;
                  hdr_digits = '0;
                  len_acc    = '0;
               end
               if (hit_err) begin
                  r.done   = 1'b1;
                  r.status = ST_ERR;
               end else if (hit_ok) begin
                  fr_open = 1'b0;
                  owed    = '0;
               end
            end
         end
      end
      r.count = deliv_cnt;
      if (r.done) parser_clear();
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender: entered and left at a falling edge
   // ---------------------------------------------------------------
   task automatic send_item(input logic act, input logic [7:0] b, input logic chk,
                            input ext_result_type fixed_res);
      ext_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      r = ipd_predict(act, b);
      res_due.push_back(chk ? fixed_res : r);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic feed_byte(input logic [7:0] b);
      send_item(ACT_BYTE, b, CHK_NONE, NO_RES);
   endtask

   task automatic feed_end();
      send_item(ACT_END, 8'($urandom_range(255)), CHK_NONE, NO_RES);
   endtask

   task automatic feed_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) feed_byte(s[i]);
   endtask

   // wait with the input idle until every result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (res_due.size() != 0);
   endtask

   // payload and noise bytes, often drawn from the characters the parser reacts to
   function automatic logic [7:0] spicy_byte();
      string spice;
      spice = "+IPD,ERROK:09\r\n";
      if ($urandom_range(3) == 0) return spice[$urandom_range(spice.len() - 1)];
      return 8'($urandom_range(255));
   endfunction

   task automatic random_sequence();
      int kind, len_val, n, cut;
      string digits, pat;
      kind = $urandom_range(99);
      if (kind < 50) begin
         // well-formed frame with random content, sometimes bent
         feed_str("+IPD,");
         len_val = ($urandom_range(7) == 0) ? $urandom_range(17, 9999) : $urandom_range(0, 16);
         digits  = $sformatf("%0d", len_val);
         case ($urandom_range(11))
            0: digits = {"0", digits};     // leading zero, may push a digit past the limit
            1: digits = {digits, "5"};     // extra digit
            2: digits = {digits, "q"};     // non-digit stops the length
            3: digits = "";                // empty length
            default: ;
         endcase
         feed_str(digits);
         if ($urandom_range(24) == 0) begin
            feed_end();                    // stream ends inside the header
            return;
         end
         feed_byte(CH_COLON);
         n = (len_val > 24) ? $urandom_range(0, 24) : len_val;
         if ($urandom_range(5) == 0) n = $urandom_range(0, n);
         repeat (n) feed_byte(spicy_byte());
      end else if (kind < 60) begin
         // broken pattern
         case ($urandom_range(2))
            0:       pat = "+IPD,";
            1:       pat = "ERROR\r\n";
            default: pat = "OK\r\n\r\n";
         endcase
         cut = $urandom_range(1, pat.len() - 1);
         feed_str(pat.substr(0, cut - 1));
         feed_byte(8'($urandom_range(255)));
      end else if (kind < 70) begin
         feed_str("ERROR\r\n");
      end else if (kind < 80) begin
         feed_str("OK\r\n\r\n");
      end else if (kind < 90) begin
         feed_end();
      end else begin
         repeat ($urandom_range(1, 8)) feed_byte(spicy_byte());
      end
   endtask

   // ---------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------
   initial begin : rsp_drive
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic check_field(input string what, input int want_v, input int got_v);
      if (want_v != got_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      ext_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata[7:0], rsp_tdata[23:8], rsp_tlast, rsp_tuser[1]};
         n_results++;
         if (got.pv) n_payload++;
         if (got.done) begin
            n_runs++;
            if (got.status) n_runs_err++;
         end
         if (res_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item, expected none, got %h", $time, got);
         end else begin
            want = res_due.pop_front();
            check_field("payload_valid", int'(want.pv),     int'(got.pv));
            check_field("payload_byte",  int'(want.pbyte),  int'(got.pbyte));
            check_field("payload_count", int'(want.count),  int'(got.count));
            check_field("done",          int'(want.done),   int'(got.done));
            check_field("status",        int'(want.status), int'(got.status));
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   dir_row_type dir_table[$];
   int          idle_send[4] = '{0, 71, 0, 27};
   int          idle_rsp[4]  = '{0, 0, 71, 27};

   initial begin
      int i, ph, goal;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      parser_clear();

      dir_table = '{
         {ACT_END,  8'h00, CHK_FIXED, DONE_OK_ZERO},   // end right after reset
         {ACT_BYTE, "+",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "I",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "P",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "D",   CHK_NONE,  NO_RES},
         {ACT_BYTE, ",",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "1",   CHK_NONE,  NO_RES},
         {ACT_BYTE, ":",   CHK_NONE,  NO_RES},
         {ACT_BYTE, 8'hFF, CHK_FIXED, PAYLOAD_FF},     // single payload byte, top value
         {ACT_END,  8'hFF, CHK_FIXED, DONE_OK_ONE},    // frame complete, run ends fine
         {ACT_BYTE, "+",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "I",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "P",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "D",   CHK_NONE,  NO_RES},
         {ACT_BYTE, ",",   CHK_NONE,  NO_RES},
         {ACT_END,  8'h00, CHK_FIXED, DONE_ERR_ZERO},  // ends inside the header
         {ACT_BYTE, "E",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "R",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "R",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "O",   CHK_NONE,  NO_RES},
         {ACT_BYTE, "R",   CHK_NONE,  NO_RES},
         {ACT_BYTE, 8'h0D, CHK_NONE,  NO_RES},
         {ACT_BYTE, 8'h0A, CHK_FIXED, DONE_ERR_ZERO},  // ERROR line
         {ACT_BYTE, 8'h00, CHK_NONE,  NO_RES},
         {ACT_END,  8'h00, CHK_FIXED, DONE_OK_ZERO}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, no idling
      for (i = 0; i < dir_table.size(); i++)
         send_item(dir_table[i].act, dir_table[i].rx, dir_table[i].chk, dir_table[i].want);
      drain();

      // random sequences over the idling phases
      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_send[ph];
         rsp_stall_pct = idle_rsp[ph];
         goal = sent_items + RAND_ITEMS / 4;
         while (sent_items < goal) random_sequence();
         feed_end();
         drain();
      end

      // byte limit while payload is still owed; the receiver holds off at the start
      // so the input stalls
      send_idle_pct = 0;
      rsp_stall_pct = 27;
      hold_requests++;
      feed_str("+IPD,1600:");
      repeat (BYTE_LIMIT) feed_byte(8'($urandom_range(255)));
      feed_end();

      req_tvalid <= 1'b0;
      while (res_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d input items, %0d results, %0d payload bytes", sent_items,
               n_results, n_payload);
      $display("%0d runs finished, %0d of them with error", n_runs, n_runs_err);
      if (errors == 0 && res_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // run limit, far above the slowest correct run
   initial begin
      #(8_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule
